/* design/ybgr_pkg.sv */
// Types, widths and coefficient tables for the YUV to BGR pixel pair unit.
// No dependencies; imported by yuv_to_bgr_pixel_pair_unit, yuv_bgr_pair_checker and the testbench.
package ybgr_pkg;

  // Fixed-point format of the conversion coefficients
  localparam int COEFF_FRAC_BITS = 16;
  localparam int COEFF_W         = COEFF_FRAC_BITS + 3;  // sign + up to 2.x
  localparam int SAMPLE_W        = 9;                    // signed luma or chroma
  localparam int PROD_W          = COEFF_W + SAMPLE_W;
  localparam int ACC_W           = PROD_W + 2;           // sum of three products
  localparam int NUM_MATRICES    = 3;
  localparam int NUM_COEFFS      = 7;

  typedef enum logic [1:0] {
    MAT_JPEG      = 2'd0,
    MAT_SMPTE170M = 2'd1,
    MAT_REC709    = 2'd2
  } matrix_e;

  typedef logic signed [COEFF_W-1:0] coeff_t;

  typedef struct packed {
    coeff_t ry;
    coeff_t rv;
    coeff_t gy;
    coeff_t gu;
    coeff_t gv;
    coeff_t by;
    coeff_t bu;
  } coeff_set_t;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] cb_first;
    logic [7:0] cr_first;
    logic [7:0] cb_second;
    logic [7:0] cr_second;
  } yuv_pair_t;

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
  } bgr_pair_t;

  // Matrix coefficients in thousandths: ry, rv, gy, gu, gv, by, bu
  localparam int MILLI_COEFFS [NUM_MATRICES][NUM_COEFFS] = '{
    '{1000, 1402, 1000, -344, -714, 1000, 1772},
    '{1164, 1596, 1164, -392, -813, 1164, 2017},
    '{1164, 1793, 1164, -213, -533, 1164, 2112}
  };

  // Round a value in thousandths to fixed point, halves away from zero
  function automatic longint to_fixed(int milli);
    longint scale;
    scale = longint'(1) << COEFF_FRAC_BITS;
    if (milli < 0) begin
      return -((longint'(-milli) * scale + 500) / 1000);
    end
    return (longint'(milli) * scale + 500) / 1000;
  endfunction

  function automatic coeff_set_t make_coeff_set(int m);
    coeff_set_t c;
    c.ry = COEFF_W'(to_fixed(MILLI_COEFFS[m][0]));
    c.rv = COEFF_W'(to_fixed(MILLI_COEFFS[m][1]));
    c.gy = COEFF_W'(to_fixed(MILLI_COEFFS[m][2]));
    c.gu = COEFF_W'(to_fixed(MILLI_COEFFS[m][3]));
    c.gv = COEFF_W'(to_fixed(MILLI_COEFFS[m][4]));
    c.by = COEFF_W'(to_fixed(MILLI_COEFFS[m][5]));
    c.bu = COEFF_W'(to_fixed(MILLI_COEFFS[m][6]));
    return c;
  endfunction

  localparam coeff_set_t COEFFS_JPEG      = make_coeff_set(0);
  localparam coeff_set_t COEFFS_SMPTE170M = make_coeff_set(1);
  localparam coeff_set_t COEFFS_REC709    = make_coeff_set(2);

endpackage

/* design/yuv_to_bgr_pixel_pair_unit.sv */
// YUV to BGR conversion of one pixel pair per clock, four register stages.
// An accepted pair passes the capture, multiply, sum and clamp registers and
// then shows on bgr_o with result_valid_o. Throughput: one pair per cycle;
// busy stays low since the receiver cannot stall and every stage advances
// each cycle.
// Reset: asynchronous, active low; clears stage valid bits and sets the
// matrix select to full-range JPEG. Depends on ybgr_pkg.
module yuv_to_bgr_pixel_pair_unit import ybgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  // command side
  input  logic       start,
  output logic       busy,
  input  yuv_pair_t  pixels_i,
  // result side
  output logic       result_valid_o,
  output bgr_pair_t  bgr_o
);

  localparam int LANES = 2;

  logic [1:0] matrix_select_q;
  coeff_set_t coeff_sel;
  logic       accept;

  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: samples and coefficients
  coeff_set_t                  coeff_q;
  logic signed [SAMPLE_W-1:0]  y_d [LANES];
  logic signed [SAMPLE_W-1:0]  u_d [LANES];
  logic signed [SAMPLE_W-1:0]  v_d [LANES];
  logic signed [SAMPLE_W-1:0]  y_q [LANES];
  logic signed [SAMPLE_W-1:0]  u_q [LANES];
  logic signed [SAMPLE_W-1:0]  v_q [LANES];

  // stage 2: products
  logic signed [PROD_W-1:0] p_ry_q [LANES];
  logic signed [PROD_W-1:0] p_rv_q [LANES];
  logic signed [PROD_W-1:0] p_gy_q [LANES];
  logic signed [PROD_W-1:0] p_gu_q [LANES];
  logic signed [PROD_W-1:0] p_gv_q [LANES];
  logic signed [PROD_W-1:0] p_by_q [LANES];
  logic signed [PROD_W-1:0] p_bu_q [LANES];

  // stage 3: sums
  logic signed [ACC_W-1:0] acc_r_q [LANES];
  logic signed [ACC_W-1:0] acc_g_q [LANES];
  logic signed [ACC_W-1:0] acc_b_q [LANES];

  // stage 4: clamped colors
  logic [7:0] red_d   [LANES];
  logic [7:0] green_d [LANES];
  logic [7:0] blue_d  [LANES];
  logic [7:0] red_q   [LANES];
  logic [7:0] green_q [LANES];
  logic [7:0] blue_q  [LANES];

  // Floor to integer and clamp to 0..255
  function automatic logic [7:0] floor_clamp(logic signed [ACC_W-1:0] acc);
    if (acc[ACC_W-1]) begin
      return 8'd0;
    end
    if (|acc[ACC_W-2:COEFF_FRAC_BITS+8]) begin
      return 8'hFF;
    end
    return acc[COEFF_FRAC_BITS+7:COEFF_FRAC_BITS];
  endfunction

  assign accept      = start && !busy;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Hold the matrix select; user must write it only while idle, not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_select_q <= MAT_JPEG;
    end else if (cfg_valid_i && cfg_ready_o) begin
      matrix_select_q <= cfg_data_i;
    end
  end

  // Pick the coefficient set; the unused code falls back to JPEG
  always_comb begin
    case (matrix_e'(matrix_select_q))
      MAT_SMPTE170M: coeff_sel = COEFFS_SMPTE170M;
      MAT_REC709:    coeff_sel = COEFFS_REC709;
      default:       coeff_sel = COEFFS_JPEG;
    endcase
  end

  // Remove the chroma offset and zero-extend the samples to the signed sample width
  always_comb begin
    y_d[0] = $signed({1'b0, pixels_i.luma_first});
    y_d[1] = $signed({1'b0, pixels_i.luma_second});
    u_d[0] = $signed({1'b0, pixels_i.cb_first})  - $signed(SAMPLE_W'(128));
    v_d[0] = $signed({1'b0, pixels_i.cr_first})  - $signed(SAMPLE_W'(128));
    u_d[1] = $signed({1'b0, pixels_i.cb_second}) - $signed(SAMPLE_W'(128));
    v_d[1] = $signed({1'b0, pixels_i.cr_second}) - $signed(SAMPLE_W'(128));
  end

  // Advance the valid bits one stage per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Payload stages: capture, multiply, sum, clamp
  always_ff @(posedge clk_i) begin
    if (accept) begin
      coeff_q <= coeff_sel;
    end
    for (int i = 0; i < LANES; i++) begin
      if (accept) begin
        y_q[i] <= y_d[i];
        u_q[i] <= u_d[i];
        v_q[i] <= v_d[i];
      end
      if (v1_q) begin
        p_ry_q[i] <= PROD_W'(coeff_q.ry) * PROD_W'(y_q[i]);
        p_rv_q[i] <= PROD_W'(coeff_q.rv) * PROD_W'(v_q[i]);
        p_gy_q[i] <= PROD_W'(coeff_q.gy) * PROD_W'(y_q[i]);
        p_gu_q[i] <= PROD_W'(coeff_q.gu) * PROD_W'(u_q[i]);
        p_gv_q[i] <= PROD_W'(coeff_q.gv) * PROD_W'(v_q[i]);
        p_by_q[i] <= PROD_W'(coeff_q.by) * PROD_W'(y_q[i]);
        p_bu_q[i] <= PROD_W'(coeff_q.bu) * PROD_W'(u_q[i]);
      end
      if (v2_q) begin
        acc_r_q[i] <= ACC_W'(p_ry_q[i]) + ACC_W'(p_rv_q[i]);
        acc_g_q[i] <= ACC_W'(p_gy_q[i]) + ACC_W'(p_gu_q[i]) + ACC_W'(p_gv_q[i]);
        acc_b_q[i] <= ACC_W'(p_by_q[i]) + ACC_W'(p_bu_q[i]);
      end
      if (v3_q) begin
        red_q[i]   <= red_d[i];
        green_q[i] <= green_d[i];
        blue_q[i]  <= blue_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      red_d[i]   = floor_clamp(acc_r_q[i]);
      green_d[i] = floor_clamp(acc_g_q[i]);
      blue_d[i]  = floor_clamp(acc_b_q[i]);
    end
  end

  assign result_valid_o      = v4_q;
  assign bgr_o.blue_first    = blue_q[0];
  assign bgr_o.green_first   = green_q[0];
  assign bgr_o.red_first     = red_q[0];
  assign bgr_o.blue_second   = blue_q[1];
  assign bgr_o.green_second  = green_q[1];
  assign bgr_o.red_second    = red_q[1];

  // Every accepted pair produces a result on result_valid_o
  a_result_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 result_valid_o)
    else $error("accepted pair produced no result");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 4))
    else $error("result without an accepted pair");

  // A negative red sum of the first pixel clamps to zero
  a_negative_clamps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && acc_r_q[0][ACC_W-1]) |=> (bgr_o.red_first == 8'd0))
    else $error("negative red sum not clamped to zero");

  // A configuration transfer updates the matrix select
  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (matrix_select_q == $past(cfg_data_i)))
    else $error("configuration transfer not taken");

endmodule

/* sim/yuv_bgr_pair_checker.sv */
// Checker for the YUV to BGR pixel pair unit: tracks the matrix select, predicts each BGR pair
// from the accepted YUV pair and compares it with the next strobed result.
// Depends on ybgr_pkg for the payload types, the matrix codes and the fraction width.
`timescale 1ns / 100ps

module yuv_bgr_pair_checker import ybgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_data_i,
  input  logic       start_i,
  input  logic       busy_i,
  input  yuv_pair_t  pixels_i,
  input  logic       result_valid_i,
  input  bgr_pair_t  bgr_i,
  output int         fail_count_o,
  output int         outstanding_o
);

  // Coefficient positions within one matrix row
  typedef enum int {K_RY, K_RV, K_GY, K_GU, K_GV, K_BY, K_BU} coeff_pos_e;

  // Matrices in thousandths
  localparam int JPEG_MILLI   [7] = '{1000, 1402, 1000, -344, -714, 1000, 1772};
  localparam int SMPTE_MILLI  [7] = '{1164, 1596, 1164, -392, -813, 1164, 2017};
  localparam int REC709_MILLI [7] = '{1164, 1793, 1164, -213, -533, 1164, 2112};

  logic [1:0] matrix_sel;
  bgr_pair_t  pending_bgr_q [$];
  bgr_pair_t  want;
  int         n_reported;
  int unsigned n_results;

  // Scale thousandths to the coefficient format, halves away from zero
  function automatic longint fixed_coeff(int milli);
    longint mag;
    longint q;
    mag = (milli < 0) ? -longint'(milli) : longint'(milli);
    q = (2 * mag * (longint'(1) << COEFF_FRAC_BITS) + 1000) / 2000;
    return (milli < 0) ? -q : q;
  endfunction

  // Floor the fixed-point sum and clamp it to a byte
  function automatic logic [7:0] floor_to_byte(longint acc);
    longint whole;
    if (acc < 0) return 8'd0;
    whole = acc >>> COEFF_FRAC_BITS;
    if (whole > 255) return 8'd255;
    return whole[7:0];
  endfunction

  // One pixel: returns {blue, green, red}
  function automatic logic [23:0] convert_pixel(logic [1:0] sel, logic [7:0] y8,
                                                logic [7:0] cb8, logic [7:0] cr8);
    int     mk [7];
    longint y, u, v;
    logic [7:0] b, g, r;
    case (sel)
      MAT_SMPTE170M: mk = SMPTE_MILLI;
      MAT_REC709:    mk = REC709_MILLI;
      default:       mk = JPEG_MILLI;  // unused code falls back to full-range JPEG
    endcase
    y = longint'(y8);
    u = longint'(cb8) - 128;
    v = longint'(cr8) - 128;
    r = floor_to_byte(fixed_coeff(mk[K_RY]) * y + fixed_coeff(mk[K_RV]) * v);
    g = floor_to_byte(fixed_coeff(mk[K_GY]) * y + fixed_coeff(mk[K_GU]) * u
                      + fixed_coeff(mk[K_GV]) * v);
    b = floor_to_byte(fixed_coeff(mk[K_BY]) * y + fixed_coeff(mk[K_BU]) * u);
    return {b, g, r};
  endfunction

  function automatic bgr_pair_t predict_bgr_pair(logic [1:0] sel, yuv_pair_t p);
    bgr_pair_t q;
    {q.blue_first, q.green_first, q.red_first} =
      convert_pixel(sel, p.luma_first, p.cb_first, p.cr_first);
    {q.blue_second, q.green_second, q.red_second} =
      convert_pixel(sel, p.luma_second, p.cb_second, p.cr_second);
    return q;
  endfunction

  task automatic check_field(string field, int unsigned idx, logic [7:0] exp_v,
                             logic [7:0] act_v);
    if (act_v !== exp_v) begin
      fail_count_o++;
      if (n_reported < 10) begin
        n_reported++;
        $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
                 $time, idx, field, exp_v, act_v);
      end
    end
  endtask

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
    n_reported    = 0;
    n_results     = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_sel <= MAT_JPEG;
    end else begin
      // Take the register write
      if (cfg_valid_i && cfg_ready_i) begin
        matrix_sel <= cfg_data_i;
      end
      // Compare a strobed result with the oldest prediction
      if (result_valid_i) begin
        if (pending_bgr_q.size() == 0) begin
          fail_count_o++;
          if (n_reported < 10) begin
            n_reported++;
            $display("%0t: result with no pending pair: %h", $time, bgr_i);
          end
        end else begin
          want = pending_bgr_q.pop_front();
          check_field("blue_first",   n_results, want.blue_first,   bgr_i.blue_first);
          check_field("green_first",  n_results, want.green_first,  bgr_i.green_first);
          check_field("red_first",    n_results, want.red_first,    bgr_i.red_first);
          check_field("blue_second",  n_results, want.blue_second,  bgr_i.blue_second);
          check_field("green_second", n_results, want.green_second, bgr_i.green_second);
          check_field("red_second",   n_results, want.red_second,   bgr_i.red_second);
        end
        n_results++;
      end
      // Predict on each command transfer
      if (start_i && !busy_i) begin
        pending_bgr_q.push_back(predict_bgr_pair(matrix_sel, pixels_i));
      end
      outstanding_o = pending_bgr_q.size();
    end
  end

endmodule

/* sim/tb_yuv_to_bgr_pixel_pair_unit.sv */
// Testbench top for yuv_to_bgr_pixel_pair_unit: clock, reset, directed pixel pairs under the
// reset matrix, random pairs under every matrix select, random gaps; checking sits in
// yuv_bgr_pair_checker. Depends on ybgr_pkg, yuv_bgr_pair_checker and the unit itself.
`timescale 1ns / 100ps

module tb_yuv_to_bgr_pixel_pair_unit;
  import ybgr_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;
  logic       start;
  logic       busy;
  yuv_pair_t  pixels;
  logic       result_valid;
  bgr_pair_t  bgr;
  int         fail_count;
  int         outstanding;

  yuv_to_bgr_pixel_pair_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .start          (start),
    .busy           (busy),
    .pixels_i       (pixels),
    .result_valid_o (result_valid),
    .bgr_o          (bgr)
  );

  yuv_bgr_pair_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .start_i        (start),
    .busy_i         (busy),
    .pixels_i       (pixels),
    .result_valid_i (result_valid),
    .bgr_i          (bgr),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard stop for a hung run
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic yuv_pair_t make_pair(logic [7:0] y0, logic [7:0] y1, logic [7:0] u0,
                                          logic [7:0] v0, logic [7:0] u1, logic [7:0] v1);
    yuv_pair_t p;
    p.luma_first  = y0;
    p.luma_second = y1;
    p.cb_first    = u0;
    p.cr_first    = v0;
    p.cb_second   = u1;
    p.cr_second   = v1;
    return p;
  endfunction

  // Bias samples toward the rails and mid-scale chroma
  function automatic logic [7:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(120, 136));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic yuv_pair_t random_pair();
    return make_pair(random_sample(), random_sample(), random_sample(),
                     random_sample(), random_sample(), random_sample());
  endfunction

  // Mostly short gaps, a few long ones, and stretches with none
  function automatic int pick_gap(int k);
    int r;
    if (k % 80 < 20) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present a pair and hold it until the transfer
  task automatic send_pair(input yuv_pair_t p);
    @(negedge clk_i);
    start  <= 1'b1;
    pixels <= p;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start for an idle gap, with noise on the payload
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start  <= 1'b0;
      pixels <= random_pair();
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Drain all pending results, then write the matrix select
  task automatic load_matrix(input logic [1:0] sel);
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      send_pair(random_pair());
      idle_cycles(pick_gap(k));
    end
  endtask

  logic [1:0] phase_sel [5];

  initial begin
    phase_sel = '{MAT_REC709, 2'd3, MAT_SMPTE170M, MAT_JPEG, MAT_REC709};
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = MAT_JPEG;
    start     = 1'b0;
    pixels    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed pairs under the reset matrix
    send_pair(make_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_pair(make_pair(8'd255, 8'd255, 8'd128, 8'd128, 8'd128, 8'd128));
    idle_cycles(2);
    send_pair(make_pair(8'd0,   8'd0,   8'd128, 8'd128, 8'd128, 8'd128));
    // negative sums on one pixel, sums above 255 on the other
    send_pair(make_pair(8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd255));
    send_pair(make_pair(8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd0));
    send_pair(make_pair(8'd128, 8'd128, 8'd0,   8'd255, 8'd255, 8'd0));
    idle_cycles(5);
    send_pair(make_pair(8'd16,  8'd235, 8'd128, 8'd128, 8'd128, 8'd128));
    send_pair(make_pair(8'hAA,  8'h55,  8'hAA,  8'h55,  8'h55,  8'hAA));
    // second pixel's chroma must come from its own samples
    send_pair(make_pair(8'd200, 8'd50,  8'd60,  8'd200, 8'd200, 8'd60));
    send_pair(make_pair(8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd255));
    send_pair(make_pair(8'd1,   8'd254, 8'd127, 8'd129, 8'd129, 8'd127));
    send_pair(make_pair(8'd100, 8'd100, 8'd255, 8'd0,   8'd0,   8'd255));

    // Random phases over every matrix setting including the unused code, REC709 twice
    foreach (phase_sel[ph]) begin
      load_matrix(phase_sel[ph]);
      run_random(230);
    end

    // Drain and let the pipeline settle
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/ybgr_pkg.sv
design/yuv_to_bgr_pixel_pair_unit.sv
sim/yuv_bgr_pair_checker.sv
sim/tb_yuv_to_bgr_pixel_pair_unit.sv
